FILE: hw/rtl/mesh_hat_function_eval_top_defines.svh
// Assertion macros shared by the checker of mesh_hat_function_eval_top.
// Depends on nothing; included by the checker file.
`ifndef MESH_HAT_FUNCTION_EVAL_TOP_DEFINES_SVH
`define MESH_HAT_FUNCTION_EVAL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MHFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MHFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mhfe_pkg.sv
// Package of the mesh hat function evaluator: widths, register codes, stage types.
// Depends on nothing; imported by every module of the block.
package mhfe_pkg;

    localparam int COORD_W   = 24;
    localparam int IDX_W     = 16;
    localparam int SEG_W     = 8;
    localparam int SIDE_W    = SEG_W + 1;
    localparam int RC_W      = SEG_W;
    localparam int VAL_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SCALE_W   = SIDE_W + DIFF_W;
    localparam int OFF_W     = SCALE_W + 2;
    localparam int MUL_W     = OFF_W + DIFF_W;
    localparam int KMUL_W    = 2 * DIFF_W;
    localparam int CROSS_W   = 64;
    localparam int DEN_W     = KMUL_W;
    localparam int REM_W     = DEN_W + 1;
    localparam int NUM_TRI   = 6;
    localparam int DIV_STEPS = 4;
    localparam int DIV_UNITS = FRAC_W / DIV_STEPS;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW_X    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW_Y    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COL_X    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COL_Y    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SEGMENTS = 3'd6;

    localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(1) << FRAC_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] row_x;
        logic signed [COORD_W-1:0] row_y;
        logic signed [COORD_W-1:0] col_x;
        logic signed [COORD_W-1:0] col_y;
        logic [SEG_W-1:0]          segments;
    } t_cfg;

    typedef struct packed {
        logic                      vld;
        logic                      invalid;
        logic [NUM_TRI-1:0]        tri_mask;
        logic signed [CROSS_W-1:0] xr;
        logic signed [CROSS_W-1:0] xc;
        logic signed [CROSS_W-1:0] k;
    } t_geo;

    typedef struct packed {
        logic              vld;
        logic              invalid;
        logic              found;
        logic              sat;
        logic [DEN_W-1:0]  den;
        logic [REM_W-1:0]  rem;
        logic [FRAC_W-1:0] quo;
    } t_div;

endpackage

FILE: hw/rtl/mhfe_geom.sv
// Front stages: index split into row and column, scaled vertex offset, cross products.
// Depends on mhfe_pkg; feeds mhfe_select.
module mhfe_geom (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  mhfe_pkg::t_cfg                    i_cfg,
    input  logic                              i_vld,
    input  logic signed [mhfe_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [mhfe_pkg::COORD_W-1:0] i_query_y,
    input  logic [mhfe_pkg::IDX_W-1:0]        i_vertex_index,
    output mhfe_pkg::t_geo                    o_geo
);
    import mhfe_pkg::*;

    localparam int QH_W = RC_W / 2;

    logic [SEG_W-1:0]            w_seg;
    logic [SIDE_W-1:0]           w_side;
    logic [2*SIDE_W-1:0]         w_side_sq;
    logic signed [DIFF_W-1:0]    w_rx, w_ry, w_cx, w_cy;

    logic                        r1_vld, r1_inv;
    logic signed [COORD_W-1:0]   r1_qx, r1_qy;
    logic [IDX_W-1:0]            r1_idx;

    logic                        r2_vld, r2_inv;
    logic [IDX_W-1:0]            r2_rem, n2_rem;
    logic [QH_W-1:0]             r2_qh, n2_qh;
    logic signed [SCALE_W-1:0]   r2_sx, r2_sy;

    logic                        r3_vld, r3_inv;
    logic [RC_W-1:0]             r3_row, r3_col;
    logic [NUM_TRI-1:0]          r3_mask, n3_mask;
    logic [IDX_W-1:0]            n3_rem;
    logic [QH_W-1:0]             n3_ql;
    logic signed [SCALE_W-1:0]   r3_sx, r3_sy;

    logic                        r4_vld, r4_inv;
    logic [NUM_TRI-1:0]          r4_mask;
    logic signed [SCALE_W-1:0]   r4_sx, r4_sy, r4_rrx, r4_rry, r4_ccx, r4_ccy;

    logic                        r5_vld, r5_inv;
    logic [NUM_TRI-1:0]          r5_mask;
    logic signed [OFF_W-1:0]     r5_dx, r5_dy;

    logic                        r6_vld, r6_inv;
    logic [NUM_TRI-1:0]          r6_mask;
    logic signed [MUL_W-1:0]     r6_m1, r6_m2, r6_m3, r6_m4;
    logic signed [KMUL_W-1:0]    r6_k1, r6_k2;

    t_geo                        r7_geo;

    assign w_seg     = (i_cfg.segments == '0) ? SEG_W'(1) : i_cfg.segments;
    assign w_side    = SIDE_W'(w_seg) + SIDE_W'(1);
    assign w_side_sq = (2*SIDE_W)'(w_side) * (2*SIDE_W)'(w_side);
    assign w_rx      = DIFF_W'(i_cfg.row_x) - DIFF_W'(i_cfg.origin_x);
    assign w_ry      = DIFF_W'(i_cfg.row_y) - DIFF_W'(i_cfg.origin_y);
    assign w_cx      = DIFF_W'(i_cfg.col_x) - DIFF_W'(i_cfg.origin_x);
    assign w_cy      = DIFF_W'(i_cfg.col_y) - DIFF_W'(i_cfg.origin_y);

    always_comb begin
        logic [IDX_W:0] v_sub;
        n2_rem = r1_idx;
        n2_qh  = '0;
        for (int b = RC_W - 1; b >= QH_W; b--) begin
            v_sub = (IDX_W+1)'(w_side) << b;
            if ({1'b0, n2_rem} >= v_sub) begin
                n2_rem = n2_rem - IDX_W'(v_sub);
                n2_qh[b-QH_W] = 1'b1;
            end
        end
    end

    always_comb begin
        logic [IDX_W:0]  v_sub;
        logic [RC_W-1:0] v_row;
        logic [RC_W-1:0] v_col;
        logic            v_fr, v_lr, v_fc, v_lc;
        n3_rem = r2_rem;
        n3_ql  = '0;
        for (int b = QH_W - 1; b >= 0; b--) begin
            v_sub = (IDX_W+1)'(w_side) << b;
            if ({1'b0, n3_rem} >= v_sub) begin
                n3_rem = n3_rem - IDX_W'(v_sub);
                n3_ql[b] = 1'b1;
            end
        end
        v_row = {r2_qh, n3_ql};
        v_col = n3_rem[RC_W-1:0];
        v_fr  = (v_row == '0);
        v_lr  = (v_row == w_seg);
        v_fc  = (v_col == '0);
        v_lc  = (v_col == w_seg);
        n3_mask[0] = !v_lr && !v_lc;
        n3_mask[1] = !v_lr && !v_fc;
        n3_mask[2] = !v_lr && !v_fc;
        n3_mask[3] = !v_fr && !v_fc;
        n3_mask[4] = !v_fr && !v_lc;
        n3_mask[5] = !v_fr && !v_lc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_geo.vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_geo.vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_qx  <= i_query_x;
            r1_qy  <= i_query_y;
            r1_idx <= i_vertex_index;
            r1_inv <= (2*SIDE_W)'(i_vertex_index) >= w_side_sq;

            r2_inv <= r1_inv;
            r2_rem <= n2_rem;
            r2_qh  <= n2_qh;
            r2_sx  <= SCALE_W'($signed({1'b0, w_seg}))
                      * SCALE_W'(DIFF_W'(r1_qx) - DIFF_W'(i_cfg.origin_x));
            r2_sy  <= SCALE_W'($signed({1'b0, w_seg}))
                      * SCALE_W'(DIFF_W'(r1_qy) - DIFF_W'(i_cfg.origin_y));

            r3_inv  <= r2_inv;
            r3_row  <= {r2_qh, n3_ql};
            r3_col  <= n3_rem[RC_W-1:0];
            r3_mask <= n3_mask;
            r3_sx   <= r2_sx;
            r3_sy   <= r2_sy;

            r4_inv  <= r3_inv;
            r4_mask <= r3_mask;
            r4_sx   <= r3_sx;
            r4_sy   <= r3_sy;
            r4_rrx  <= SCALE_W'($signed({1'b0, r3_row})) * SCALE_W'(w_rx);
            r4_rry  <= SCALE_W'($signed({1'b0, r3_row})) * SCALE_W'(w_ry);
            r4_ccx  <= SCALE_W'($signed({1'b0, r3_col})) * SCALE_W'(w_cx);
            r4_ccy  <= SCALE_W'($signed({1'b0, r3_col})) * SCALE_W'(w_cy);

            r5_inv  <= r4_inv;
            r5_mask <= r4_mask;
            r5_dx   <= OFF_W'(r4_sx) - OFF_W'(r4_rrx) - OFF_W'(r4_ccx);
            r5_dy   <= OFF_W'(r4_sy) - OFF_W'(r4_rry) - OFF_W'(r4_ccy);

            r6_inv  <= r5_inv;
            r6_mask <= r5_mask;
            r6_m1   <= MUL_W'(r5_dx) * MUL_W'(w_ry);
            r6_m2   <= MUL_W'(r5_dy) * MUL_W'(w_rx);
            r6_m3   <= MUL_W'(r5_dx) * MUL_W'(w_cy);
            r6_m4   <= MUL_W'(r5_dy) * MUL_W'(w_cx);
            r6_k1   <= KMUL_W'(w_rx) * KMUL_W'(w_cy);
            r6_k2   <= KMUL_W'(w_ry) * KMUL_W'(w_cx);

            r7_geo.invalid  <= r6_inv;
            r7_geo.tri_mask <= r6_mask;
            r7_geo.xr       <= CROSS_W'(r6_m1) - CROSS_W'(r6_m2);
            r7_geo.xc       <= CROSS_W'(r6_m3) - CROSS_W'(r6_m4);
            r7_geo.k        <= CROSS_W'(r6_k1) - CROSS_W'(r6_k2);
        end
    end

    assign o_geo = r7_geo;

endmodule

FILE: hw/rtl/mhfe_select.sv
// Edge-sign tests of the six local triangles and choice of the first one that holds the point.
// Depends on mhfe_pkg; takes mhfe_geom results and feeds the divider steps.
module mhfe_select (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  mhfe_pkg::t_geo i_geo,
    output mhfe_pkg::t_div o_div
);
    import mhfe_pkg::*;

    logic signed [CROSS_W-1:0] w_na [NUM_TRI];
    logic signed [CROSS_W-1:0] w_nb [NUM_TRI];
    logic signed [CROSS_W-1:0] w_nc [NUM_TRI];
    logic [NUM_TRI-1:0]        n8_in;

    logic                      r8_vld, r8_inv;
    logic [NUM_TRI-1:0]        r8_in;
    logic [DEN_W-1:0]          r8_num [NUM_TRI];
    logic [DEN_W-1:0]          r8_den;

    t_div                      r9_div;
    logic [DEN_W-1:0]          n9_num;

    always_comb begin
        logic signed [CROSS_W-1:0] v_xr, v_xc, v_k;
        logic                      v_pos, v_neg;
        v_xr = i_geo.xr;
        v_xc = i_geo.xc;
        v_k  = i_geo.k;
        w_na[0] = v_xc - v_xr - v_k;  w_nb[0] = -v_xc;        w_nc[0] = v_xr;
        w_na[1] = v_xc - v_k;         w_nb[1] = -v_xr;        w_nc[1] = v_xr - v_xc;
        w_na[2] = v_xr - v_k;         w_nb[2] = v_xc - v_xr;  w_nc[2] = -v_xc;
        w_na[3] = v_xr - v_xc - v_k;  w_nb[3] = v_xc;         w_nc[3] = -v_xr;
        w_na[4] = -v_xc - v_k;        w_nb[4] = v_xr;         w_nc[4] = v_xc - v_xr;
        w_na[5] = v_xr + v_k;         w_nb[5] = -v_xc;        w_nc[5] = v_xc - v_xr;
        for (int t = 0; t < NUM_TRI; t++) begin
            // The last triangle winds opposite to the others, so its area is +k.
            v_pos = (t == NUM_TRI - 1) ? (v_k > 0) : (v_k < 0);
            v_neg = (t == NUM_TRI - 1) ? (v_k < 0) : (v_k > 0);
            n8_in[t] = i_geo.tri_mask[t] && !i_geo.invalid &&
                       ((v_pos && w_na[t] >= 0 && w_nb[t] >= 0 && w_nc[t] >= 0) ||
                        (v_neg && w_na[t] <= 0 && w_nb[t] <= 0 && w_nc[t] <= 0));
        end
    end

    always_comb begin
        n9_num = '0;
        for (int t = NUM_TRI - 1; t >= 0; t--) begin
            if (r8_in[t]) begin
                n9_num = r8_num[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld     <= 1'b0;
            r9_div.vld <= 1'b0;
        end else if (i_en) begin
            r8_vld     <= i_geo.vld;
            r9_div.vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_inv <= i_geo.invalid;
            r8_in  <= n8_in;
            r8_den <= (i_geo.k < 0) ? DEN_W'(-i_geo.k) : DEN_W'(i_geo.k);
            for (int t = 0; t < NUM_TRI; t++) begin
                r8_num[t] <= (w_na[t] < 0) ? DEN_W'(-w_na[t]) : DEN_W'(w_na[t]);
            end

            r9_div.invalid <= r8_inv;
            r9_div.found   <= |r8_in;
            r9_div.sat     <= n9_num >= r8_den;
            r9_div.den     <= r8_den;
            r9_div.rem     <= REM_W'(n9_num);
            r9_div.quo     <= '0;
        end
    end

    assign o_div = r9_div;

endmodule

FILE: hw/rtl/mhfe_div_step.sv
// One stage of the restoring divider: it adds DIV_STEPS (four) quotient bits of the ratio.
// Depends on mhfe_pkg; chained by the top level after mhfe_select.
module mhfe_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  mhfe_pkg::t_div i_div,
    output mhfe_pkg::t_div o_div
);
    import mhfe_pkg::*;

    t_div r_div;
    t_div n_div;

    always_comb begin
        logic [REM_W-1:0] v_rem;
        logic             v_bit;
        n_div = i_div;
        v_rem = i_div.rem;
        for (int b = 0; b < DIV_STEPS; b++) begin
            v_rem = v_rem << 1;
            v_bit = (v_rem >= REM_W'(i_div.den));
            if (v_bit) begin
                v_rem = v_rem - REM_W'(i_div.den);
            end
            n_div.quo = {n_div.quo[FRAC_W-2:0], v_bit};
        end
        n_div.rem = v_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.vld <= 1'b0;
        end else if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

FILE: hw/rtl/mesh_hat_function_eval_top.sv
// Top level of the mesh hat function evaluator: register port, stall control, pipeline.
// Depends on mhfe_pkg, mhfe_geom, mhfe_select and mhfe_div_step.
//
//   channel  direction  signals
//   query    in         i_in_valid / o_in_ready, i_query_x, i_query_y, i_vertex_index
//   result   out        o_out_valid / i_out_ready, o_basis_value, o_point_found,
//                       o_index_invalid
//   config   in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// An item passes seven stages of index split and cross products, two of triangle tests and
// choice, and four of the divider at four bits each. One item is accepted per cycle; the
// whole pipeline moves together and holds when the output register is full and not taken.
// Reset is synchronous; it clears the valid bits and sets the configuration registers to
// a unit square with one segment.
module mesh_hat_function_eval_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [mhfe_pkg::COORD_W-1:0]   i_query_x,
    input  logic signed [mhfe_pkg::COORD_W-1:0]   i_query_y,
    input  logic [mhfe_pkg::IDX_W-1:0]            i_vertex_index,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [mhfe_pkg::VAL_W-1:0]            o_basis_value,
    output logic                                  o_point_found,
    output logic                                  o_index_invalid,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mhfe_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [mhfe_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [mhfe_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import mhfe_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_en;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_reg;
    t_geo                 w_geo;
    t_div                 w_div [DIV_UNITS+1];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.row_x    <= COORD_W'(1) << FRAC_W;
            r_cfg.row_y    <= '0;
            r_cfg.col_x    <= '0;
            r_cfg.col_y    <= COORD_W'(1) << FRAC_W;
            r_cfg.segments <= SEG_W'(1);
        end else if (w_wr) begin
            unique case (w_reg)
                REG_ORIGIN_X: r_cfg.origin_x <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y: r_cfg.origin_y <= pwdata[COORD_W-1:0];
                REG_ROW_X:    r_cfg.row_x    <= pwdata[COORD_W-1:0];
                REG_ROW_Y:    r_cfg.row_y    <= pwdata[COORD_W-1:0];
                REG_COL_X:    r_cfg.col_x    <= pwdata[COORD_W-1:0];
                REG_COL_Y:    r_cfg.col_y    <= pwdata[COORD_W-1:0];
                REG_SEGMENTS: r_cfg.segments <= pwdata[SEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ORIGIN_X: prdata = APB_DATA_W'(r_cfg.origin_x);
            REG_ORIGIN_Y: prdata = APB_DATA_W'(r_cfg.origin_y);
            REG_ROW_X:    prdata = APB_DATA_W'(r_cfg.row_x);
            REG_ROW_Y:    prdata = APB_DATA_W'(r_cfg.row_y);
            REG_COL_X:    prdata = APB_DATA_W'(r_cfg.col_x);
            REG_COL_Y:    prdata = APB_DATA_W'(r_cfg.col_y);
            REG_SEGMENTS: prdata = APB_DATA_W'(r_cfg.segments);
            default:      prdata = '0;
        endcase
    end

    assign w_en       = !w_div[DIV_UNITS].vld || i_out_ready;
    assign o_in_ready = w_en;

    mhfe_geom u_geom (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_cfg          (r_cfg),
        .i_vld          (i_in_valid),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_vertex_index (i_vertex_index),
        .o_geo          (w_geo)
    );

    mhfe_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_geo   (w_geo),
        .o_div   (w_div[0])
    );

    for (genvar g = 0; g < DIV_UNITS; g++) begin : g_div
        mhfe_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_div[g]),
            .o_div   (w_div[g+1])
        );
    end

    assign o_out_valid     = w_div[DIV_UNITS].vld;
    assign o_index_invalid = w_div[DIV_UNITS].invalid;
    assign o_point_found   = w_div[DIV_UNITS].found && !w_div[DIV_UNITS].invalid;

    always_comb begin
        priority if (w_div[DIV_UNITS].invalid || !w_div[DIV_UNITS].found) begin
            o_basis_value = '0;
        end else if (w_div[DIV_UNITS].sat) begin
            o_basis_value = ONE_Q16;
        end else begin
            o_basis_value = VAL_W'(w_div[DIV_UNITS].quo);
        end
    end

endmodule

FILE: hw/rtl/mhfe_checker.sv
// Port-level checker of mesh_hat_function_eval_top and the bind that attaches it.
// Depends on mhfe_pkg and mesh_hat_function_eval_top_defines.svh.
`include "mesh_hat_function_eval_top_defines.svh"

module mhfe_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic [mhfe_pkg::VAL_W-1:0]            o_basis_value,
    input  logic                                  o_point_found,
    input  logic                                  o_index_invalid
);
    import mhfe_pkg::*;

    `MHFE_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_out_valid && o_index_invalid,
        !o_point_found && o_basis_value == '0, "Invalid index item carries a value.")
    `MHFE_ASSERT_NOW(a_missed_zero, i_clk, i_rst_n, o_out_valid && !o_point_found,
        o_basis_value == '0, "Item with no triangle carries a nonzero value.")
    `MHFE_ASSERT_NOW(a_value_range, i_clk, i_rst_n, o_out_valid,
        o_basis_value <= ONE_Q16, "Basis value above one.")
    `MHFE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_basis_value), "Stalled result item changed.")

endmodule

bind mesh_hat_function_eval_top mhfe_checker u_mhfe_checker (.*);

FILE: test/mesh_hat_function_eval_checker.sv
`timescale 1ns / 1ps
// Checker for mesh_hat_function_eval_top: follows register writes, predicts each hat value
// and compares every result item with the oldest prediction. Depends on mhfe_pkg.
module mesh_hat_function_eval_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [mhfe_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [mhfe_pkg::COORD_W-1:0] i_query_y,
    input  logic [mhfe_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [mhfe_pkg::VAL_W-1:0]          i_basis_value,
    input  logic                                i_point_found,
    input  logic                                i_index_invalid,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mhfe_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mhfe_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                                pready,
    output int                                  o_errors,
    output int                                  o_pending
);
    import mhfe_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             found;
        logic             invalid;
    } t_hat_result;

    // Row and column offsets of the B and C corners of the six local triangles.
    localparam int B_ROW [6] = '{1, 1, 0, -1, -1, -1};
    localparam int B_COL [6] = '{0, -1, -1, 0, 1, 1};
    localparam int C_ROW [6] = '{0, 1, 1, 0, -1, 0};
    localparam int C_COL [6] = '{1, 0, -1, -1, 0, 1};

    t_cfg        cfg;
    t_hat_result hat_values_q[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = hat_values_q.size();

    function automatic longint cross_prod(input longint ux, uy, vx, vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic t_hat_result eval_hat(input logic signed [COORD_W-1:0] qx, qy,
                                             input logic [IDX_W-1:0] index);
        t_hat_result res;
        longint      s, side, row, col, rx, ry, cx, cy, dx, dy;
        longint      bx, by, tx, ty, den, na, nb, nc;
        longint unsigned num, dmag, q, r;
        logic [5:0]  mask;
        bit          hit;

        res = '0;
        s = (cfg.segments == 0) ? 1 : longint'(cfg.segments);
        side = s + 1;
        if (longint'(index) >= side * side) begin
            res.invalid = 1'b1;
            return res;
        end
        row = longint'(index) / side;
        col = longint'(index) % side;
        rx = longint'(cfg.row_x) - longint'(cfg.origin_x);
        ry = longint'(cfg.row_y) - longint'(cfg.origin_y);
        cx = longint'(cfg.col_x) - longint'(cfg.origin_x);
        cy = longint'(cfg.col_y) - longint'(cfg.origin_y);
        dx = s * longint'(qx) - (s * longint'(cfg.origin_x) + row * rx + col * cx);
        dy = s * longint'(qy) - (s * longint'(cfg.origin_y) + row * ry + col * cy);

        if (row == 0) begin
            mask = (col == 0) ? 6'b000001 : (col == s) ? 6'b000110 : 6'b000111;
        end else if (row == s) begin
            mask = (col == 0) ? 6'b110000 : (col == s) ? 6'b001000 : 6'b111000;
        end else begin
            mask = (col == 0) ? 6'b110001 : (col == s) ? 6'b001110 : 6'b111111;
        end

        for (int k = 0; k < 6; k++) begin
            if (mask[k] && !res.found) begin
                bx = B_ROW[k] * rx + B_COL[k] * cx;
                by = B_ROW[k] * ry + B_COL[k] * cy;
                tx = C_ROW[k] * rx + C_COL[k] * cx;
                ty = C_ROW[k] * ry + C_COL[k] * cy;
                den = cross_prod(-bx, -by, tx - bx, ty - by);
                na = cross_prod(dx - bx, dy - by, tx - bx, ty - by);
                nb = cross_prod(dx - tx, dy - ty, -tx, -ty);
                nc = cross_prod(dx, dy, bx, by);
                if (den > 0) begin
                    hit = na >= 0 && nb >= 0 && nc >= 0;
                end else begin
                    hit = den != 0 && na <= 0 && nb <= 0 && nc <= 0;
                end
                if (hit) begin
                    num = (na < 0) ? -na : na;
                    dmag = (den < 0) ? -den : den;
                    q = 0;
                    r = num;
                    for (int i = 0; i <= FRAC_W; i++) begin
                        q = q << 1;
                        if (r >= dmag) begin
                            r = r - dmag;
                            q = q | 1;
                        end
                        r = r << 1;
                    end
                    res.value = (q > 65536) ? ONE_Q16 : VAL_W'(q);
                    res.found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hat_result want;
        int          v_err;
        v_err = 0;
        if (!i_rst_n) begin
            cfg <= '{origin_x: 0, origin_y: 0, row_x: 65536, row_y: 0,
                     col_x: 0, col_y: 65536, segments: 1};
            errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_ORIGIN_X: cfg.origin_x <= pwdata[COORD_W-1:0];
                    REG_ORIGIN_Y: cfg.origin_y <= pwdata[COORD_W-1:0];
                    REG_ROW_X:    cfg.row_x    <= pwdata[COORD_W-1:0];
                    REG_ROW_Y:    cfg.row_y    <= pwdata[COORD_W-1:0];
                    REG_COL_X:    cfg.col_x    <= pwdata[COORD_W-1:0];
                    REG_COL_Y:    cfg.col_y    <= pwdata[COORD_W-1:0];
                    REG_SEGMENTS: cfg.segments <= pwdata[SEG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                hat_values_q.push_back(eval_hat(i_query_x, i_query_y, i_vertex_index));
            end
            if (i_out_valid && i_out_ready) begin
                if (hat_values_q.size() == 0) begin
                    $error("result item with no prediction waiting");
                    v_err++;
                end else begin
                    want = hat_values_q.pop_front();
                    if (i_basis_value !== want.value) begin
                        $error("basis_value expected %0d actual %0d", want.value, i_basis_value);
                        v_err++;
                    end
                    if (i_point_found !== want.found) begin
                        $error("point_found expected %0d actual %0d", want.found, i_point_found);
                        v_err++;
                    end
                    if (i_index_invalid !== want.invalid) begin
                        $error("index_invalid expected %0d actual %0d", want.invalid,
                               i_index_invalid);
                        v_err++;
                    end
                end
            end
            errors <= errors + v_err;
        end
    end

endmodule

FILE: test/mesh_hat_function_eval_top_tb.sv
`timescale 1ns / 1ps
// Testbench top of mesh_hat_function_eval_top: drives query items and register writes over
// several mesh settings and gives the verdict. Depends on mhfe_pkg, the top module and the checker module.
module mesh_hat_function_eval_top_tb;
    import mhfe_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 30;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] query_x = '0;
    logic signed [COORD_W-1:0] query_y = '0;
    logic [IDX_W-1:0]          vertex_index = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [VAL_W-1:0]          basis_value;
    logic                      point_found;
    logic                      index_invalid;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0]     pwdata = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    int                        errors;
    int                        pending;
    int                        cycles = 0;
    int                        items_sent = 0;
    int                        meshes = 0;
    bit                        steady = 1'b0;

    // Mesh as the stimulus sees it, for placing points near vertices.
    longint m_ox, m_oy, m_rx, m_ry, m_cx, m_cy, m_seg;

    always #2 clk = ~clk;

    mesh_hat_function_eval_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_query_x(query_x), .i_query_y(query_y), .i_vertex_index(vertex_index),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_basis_value(basis_value), .o_point_found(point_found),
        .o_index_invalid(index_invalid),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mesh_hat_function_eval_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_query_x(query_x), .i_query_y(query_y), .i_vertex_index(vertex_index),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_basis_value(basis_value), .i_point_found(point_found),
        .i_index_invalid(index_invalid),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The result side stalls in short and long bursts, except while steady is set.
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = gap_length();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input longint value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= APB_ADDR_W'(idx) << 2;
        pwdata <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_mesh(input longint ox, oy, rx, ry, cx, cy, seg);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ROW_X, rx);
        write_reg(REG_ROW_Y, ry);
        write_reg(REG_COL_X, cx);
        write_reg(REG_COL_Y, cy);
        write_reg(REG_SEGMENTS, seg);
        m_ox = ox; m_oy = oy; m_rx = rx; m_ry = ry; m_cx = cx; m_cy = cy;
        m_seg = (seg == 0) ? 1 : seg;
        meshes++;
    endtask

    task automatic send_item(input longint x, y, input int idx);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        query_x <= COORD_W'(x);
        query_y <= COORD_W'(y);
        vertex_index <= IDX_W'(idx);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    function automatic longint clamp_coord(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint pick_step();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 0;
        if (r < 3) return 48;
        if (r < 4) return -48;
        return $urandom_range(0, 120) - 60;
    endfunction

    // Mostly points around a valid vertex, some on its edges; the rest is noise.
    task automatic send_random(input int count);
        longint side, row, col, a, b, px, py;
        int     kind;
        for (int n = 0; n < count; n++) begin
            side = m_seg + 1;
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                row = $urandom_range(0, 9) < 3 ? ($urandom_range(0, 1) ? m_seg : 0)
                                                : $urandom_range(0, m_seg);
                col = $urandom_range(0, 9) < 3 ? ($urandom_range(0, 1) ? m_seg : 0)
                                                : $urandom_range(0, m_seg);
                a = pick_step();
                b = pick_step();
                px = (m_seg * m_ox + row * (m_rx - m_ox) + col * (m_cx - m_ox)) / m_seg
                     + (a * (m_rx - m_ox) + b * (m_cx - m_ox)) / (48 * m_seg);
                py = (m_seg * m_oy + row * (m_ry - m_oy) + col * (m_cy - m_oy)) / m_seg
                     + (a * (m_ry - m_oy) + b * (m_cy - m_oy)) / (48 * m_seg);
                send_item(clamp_coord(px), clamp_coord(py), int'(row * side + col));
            end else if (kind < 92) begin
                send_item($signed(24'($urandom)), $signed(24'($urandom)),
                          $urandom_range(0, side * side - 1));
            end else begin
                send_item($signed(24'($urandom)), $signed(24'($urandom)), 16'($urandom));
            end
        end
    endtask

    function automatic longint rnd_coord(input int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    initial begin
        m_ox = 0; m_oy = 0; m_rx = 65536; m_ry = 0; m_cx = 0; m_cy = 65536; m_seg = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset mesh: unit square with one segment.
        send_item(0, 0, 0);
        send_item(32768, 32768, 0);
        send_item(16384, 16384, 0);
        send_item(65536, 65536, 3);
        send_item(40000, 20000, 3);
        send_item(65536, 0, 1);
        send_item(0, 65536, 2);
        send_item(-1, 0, 0);
        send_item(100000, 100000, 3);
        send_item(0, 0, 4);
        send_item(0, 0, 65535);
        send_item(-8388608, -8388608, 0);
        send_item(8388607, 8388607, 3);
        send_item(-8388608, 8388607, 1);
        send_item(8388607, -8388608, 2);
        send_item(21845, 21845, 1);

        set_mesh(0, 0, 0, 0, 0, 0, 0);
        send_item(0, 0, 0);
        send_item(0, 0, 3);
        set_mesh(0, 0, 262144, 0, 0, 262144, 0);
        send_item(10000, 10000, 0);
        send_item(0, 0, 4);
        send_random(60);

        set_mesh(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607, 255);
        send_item(-8388608, -8388608, 0);
        send_item(8388607, 8388607, 65535);
        send_item(0, 0, 65535);
        send_random(150);

        set_mesh(8388607, 8388607, 8388607, -8388608, -8388608, 8388607, 7);
        send_random(150);

        set_mesh(0, 0, 65536, 65536, 131072, 131072, 5);
        send_random(60);

        steady = 1'b1;
        set_mesh(0, 0, 0, 131072, 131072, 0, 3);
        send_random(120);
        steady = 1'b0;

        for (int p = 0; p < 9; p++) begin
            set_mesh(rnd_coord(4000000), rnd_coord(4000000), rnd_coord(8388607),
                     rnd_coord(8388607), rnd_coord(8388607), rnd_coord(8388607),
                     (p == 8) ? $urandom_range(100, 255) : $urandom_range(1, 12));
            send_random(140);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d query items over %0d mesh settings, including degenerate and",
                 items_sent, meshes + 1);
        $display("mirrored meshes, extreme corners and out-of-mesh vertex indices.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mhfe_pkg.sv
hw/rtl/mhfe_geom.sv
hw/rtl/mhfe_select.sv
hw/rtl/mhfe_div_step.sv
hw/rtl/mesh_hat_function_eval_top.sv
hw/rtl/mhfe_checker.sv
test/mesh_hat_function_eval_checker.sv
test/mesh_hat_function_eval_top_tb.sv
